FILE: sv/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg: shared types, constants and CRC helper
// Constants, result record and status codes for the reply frame checker.
// ----------------------------------------------------------------------------
package frc_pkg;

  // Largest frame the checker accepts; longer configured lengths are clamped
  localparam int MAX_FRAME = 64;

  // Byte counter holds 0 .. MAX_FRAME-1
  localparam int CNT_W = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  // Working width for index and length compares (holds MAX_FRAME and 255+5)
  localparam int CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 2;

  localparam int CFG_W  = 7;
  localparam int IDX_W  = 6;

  localparam logic [7:0] HDR_BYTE      = 8'hA5;
  localparam logic [7:0] ERR_CODE_A    = 8'h83;
  localparam logic [7:0] ERR_CODE_B    = 8'h90;
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
  localparam int         LEN_OVERHEAD  = 5;
  localparam int         PAYLOAD_FIRST = 4;
  localparam logic [CFG_W-1:0] FRAME_LEN_RESET = 7'd6;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_LEN_ERR   = 3'd2,
    ST_BAD_HDR   = 3'd3,
    ST_CRC_ERR   = 3'd4,
    ST_ERR_REPLY = 3'd5
  } frame_status_t;

  typedef struct packed {
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       data_byte;
    logic             in_payload;
    logic             frame_done;
    logic [2:0]       frame_status;
    logic [7:0]       reply_code;
    logic [7:0]       length_field;
  } frc_result_t;

  // Reflected Dallas/Maxim CRC-8 update over one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/response_frame_checker_top.sv
// ----------------------------------------------------------------------------
// response_frame_checker_top: reply frame checker with CRC-8
// Echoes each received byte with its position and reports frame status on
// the last byte of each frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one received byte per transfer;
//   in_frame_start marks byte 0 of a new frame and drops any partial frame.
//   Output channel (out_valid/out_ready) returns one result per input byte:
//   its index, the byte itself, a payload flag and, on the last byte of the
//   frame, status, function code and length byte.
//   cfg_we/cfg_wdata set the expected frame length; write it while idle.
//   Results are registered in the output stage, or in the skid entry on
//   a stall. Throughput is one byte per cycle unless the receiver stalls,
//   set by the combinational CRC and status logic feeding the output register.
//   When the receiver stalls, one more byte is taken into a skid entry, then
//   in_ready drops until the output drains.
//   Reset (rst_n low, synchronous) empties the output buffer, clears the
//   frame state and sets the frame length to 6.
// ----------------------------------------------------------------------------
module response_frame_checker_top
  import frc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  input  logic             in_frame_start,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_byte_index,
  output logic [7:0]       out_data_byte,
  output logic             out_in_payload,
  output logic             out_frame_done,
  output logic [2:0]       out_frame_status,
  output logic [7:0]       out_reply_code,
  output logic [7:0]       out_length_field
);

  frc_result_t core_result, out_result;
  logic        in_fire;

  assign in_fire = in_valid && in_ready;

  // Frame state and status logic
  frc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_fire        (in_fire),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .result         (core_result)
  );

  // Output register and skid
  frc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (core_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_result)
  );

  assign out_byte_index   = out_result.byte_index;
  assign out_data_byte    = out_result.data_byte;
  assign out_in_payload   = out_result.in_payload;
  assign out_frame_done   = out_result.frame_done;
  assign out_frame_status = out_result.frame_status;
  assign out_reply_code   = out_result.reply_code;
  assign out_length_field = out_result.length_field;

endmodule

FILE: sv/frc_core.sv
// ----------------------------------------------------------------------------
// frc_core: frame tracking and status logic
// Holds the byte counter, running CRC and captured header fields, and forms
// the result record for the byte presented at the input.
// ----------------------------------------------------------------------------
module frc_core
  import frc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_fire,
  input  logic [7:0]       in_rx_byte,
  input  logic             in_frame_start,
  output frc_result_t      result
);

  logic [CFG_W-1:0] frame_length_r;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             hdr_good_r, hdr_good_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [7:0]       len_r, len_nxt;

  logic [CMP_W-1:0] fl_w, n_w, idx_w, len_sum;
  logic [7:0]       crc_eff;
  logic             done, payload;
  frame_status_t    status;

  // Clamp the configured length into 1 .. MAX_FRAME
  always_comb begin
    fl_w = CMP_W'(frame_length_r);
    if (fl_w == '0) begin
      n_w = CMP_W'(1);
    end else if (fl_w > CMP_W'(MAX_FRAME)) begin
      n_w = CMP_W'(MAX_FRAME);
    end else begin
      n_w = fl_w;
    end
  end

  // Index of this byte and frame fields as seen after taking it in
  always_comb begin
    idx_w        = in_frame_start ? '0 : CMP_W'(byte_count_r);
    crc_eff      = crc_r;
    hdr_good_nxt = hdr_good_r;
    func_nxt     = func_r;
    len_nxt      = len_r;
    if (idx_w == '0) begin
      crc_eff      = '0;
      hdr_good_nxt = (in_rx_byte == HDR_BYTE);
      func_nxt     = '0;
      len_nxt      = '0;
    end
    if (idx_w == CMP_W'(2)) begin
      func_nxt = in_rx_byte;
    end
    if (idx_w == CMP_W'(3)) begin
      len_nxt = in_rx_byte;
    end
  end

  assign done    = (idx_w >= n_w - CMP_W'(1));
  assign payload = (idx_w >= CMP_W'(PAYLOAD_FIRST)) && (n_w >= CMP_W'(2)) &&
                   (idx_w <= n_w - CMP_W'(2));
  assign len_sum = CMP_W'(len_nxt) + CMP_W'(LEN_OVERHEAD);

  // Judge the frame in priority order
  always_comb begin
    priority if (n_w < CMP_W'(LEN_OVERHEAD)) begin
      status = ST_SHORT;
    end else if (len_sum != n_w) begin
      status = ST_LEN_ERR;
    end else if (!hdr_good_nxt) begin
      status = ST_BAD_HDR;
    end else if (crc_eff != in_rx_byte) begin
      status = ST_CRC_ERR;
    end else if (func_nxt == ERR_CODE_A || func_nxt == ERR_CODE_B) begin
      status = ST_ERR_REPLY;
    end else begin
      status = ST_OK;
    end
  end

  // Advance counter and CRC; the header byte and the last byte (the CRC byte) are not folded in
  always_comb begin
    if (done) begin
      byte_count_nxt = '0;
      crc_nxt        = crc_eff;
    end else begin
      byte_count_nxt = CNT_W'(idx_w + CMP_W'(1));
      crc_nxt        = (idx_w != '0) ? crc8_update(crc_eff, in_rx_byte) : crc_eff;
    end
  end

  // Assemble the result record
  always_comb begin
    result.byte_index   = idx_w[IDX_W-1:0];
    result.data_byte    = in_rx_byte;
    result.in_payload   = payload;
    result.frame_done   = done;
    result.frame_status = done ? status : ST_OK;
    result.reply_code   = done ? func_nxt : '0;
    result.length_field = done ? len_nxt : '0;
  end

  // Hold configuration and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= FRAME_LEN_RESET;
      byte_count_r   <= '0;
      crc_r          <= '0;
      hdr_good_r     <= 1'b0;
      func_r         <= '0;
      len_r          <= '0;
    end else begin
      if (cfg_we) begin
        frame_length_r <= cfg_wdata;
      end
      if (in_fire) begin
        byte_count_r <= byte_count_nxt;
        crc_r        <= crc_nxt;
        hdr_good_r   <= hdr_good_nxt;
        func_r       <= func_nxt;
        len_r        <= len_nxt;
      end
    end
  end

endmodule

FILE: sv/frc_out_buf.sv
// ----------------------------------------------------------------------------
// frc_out_buf: output register with skid stage
// Registers result records toward the receiver; a second entry catches a
// transfer that arrives while the receiver stalls.
// ----------------------------------------------------------------------------
module frc_out_buf
  import frc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  frc_result_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output frc_result_t out_data
);

  logic        out_valid_r, skid_valid_r;
  frc_result_t out_data_r, skid_data_r;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control: refill the output stage when it drains, else park in the skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r  <= skid_valid_r || in_valid;
      skid_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : in_data;
    end else if (in_valid && in_ready) begin
      skid_data_r <= in_data;
    end
  end

endmodule

FILE: sv/frc_checker.sv
// ----------------------------------------------------------------------------
// frc_checker: port-level assertions for the reply frame checker
// Watches the result channel and the consistency of the status fields.
// ----------------------------------------------------------------------------
module frc_checker
  import frc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_in_payload,
  input logic             out_frame_done,
  input logic [2:0]       out_frame_status,
  input logic [7:0]       out_reply_code,
  input logic [7:0]       out_length_field
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Status fields stay zero away from the last byte
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |->
      out_frame_status == ST_OK && out_reply_code == '0 && out_length_field == '0)
    else $error("status fields set before frame end");

  // Payload bytes never end a frame
  a_payload_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_in_payload && out_frame_done))
    else $error("payload byte flagged as last byte");

  // Error reply only carries one of the two error codes
  a_err_reply_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done && out_frame_status == ST_ERR_REPLY |->
      out_reply_code == ERR_CODE_A || out_reply_code == ERR_CODE_B)
    else $error("error reply status with ordinary function code");

endmodule

bind response_frame_checker_top frc_checker u_frc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_in_payload   (out_in_payload),
  .out_frame_done   (out_frame_done),
  .out_frame_status (out_frame_status),
  .out_reply_code   (out_reply_code),
  .out_length_field (out_length_field)
);

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for response_frame_checker_top
// Sends reply frames (well formed, with one flaw, or plain noise) under
// random idling on both channels. Predicts the result of every byte in the
// bench and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import frc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_BYTES  = 800;
  localparam int GAP_MAX     = 14;
  localparam int PRINT_MAX   = 40;

  typedef enum int {FL_NONE, FL_CRC, FL_HDR, FL_LEN, FL_ERR_A, FL_ERR_B} flaw_t;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             cfg_we         = 1'b0;
  logic [CFG_W-1:0] cfg_wdata      = '0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  logic [7:0]       in_rx_byte     = '0;
  logic             in_frame_start = 1'b0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [IDX_W-1:0] out_byte_index;
  logic [7:0]       out_data_byte;
  logic             out_in_payload;
  logic             out_frame_done;
  logic [2:0]       out_frame_status;
  logic [7:0]       out_reply_code;
  logic [7:0]       out_length_field;

  response_frame_checker_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_index   (out_byte_index),
    .out_data_byte    (out_data_byte),
    .out_in_payload   (out_in_payload),
    .out_frame_done   (out_frame_done),
    .out_frame_status (out_frame_status),
    .out_reply_code   (out_reply_code),
    .out_length_field (out_length_field)
  );

  always #5 clk = ~clk;

  // Frame state as the bench expects it
  logic [CFG_W-1:0] exp_frame_len = FRAME_LEN_RESET;
  int               exp_count     = 0;
  logic [7:0]       exp_crc       = '0;
  logic             exp_hdr_ok    = 1'b0;
  logic [7:0]       exp_func      = '0;
  logic [7:0]       exp_len       = '0;

  frc_result_t expected_results[$];

  int err_count    = 0;
  int bytes_sent   = 0;
  int frames_done  = 0;
  int cycles       = 0;
  int status_seen[6];
  int tx_gap_max   = GAP_MAX;
  int rx_stall_max = GAP_MAX;
  int rx_hold      = 0;

  // Reflected CRC-8 (0x31 polynomial), one input bit at a time, LSB first
  function automatic logic [7:0] dow_crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY_REFL;
      end
    end
    return c;
  endfunction

  // Zero counts as one byte, anything past MAX_FRAME as MAX_FRAME
  function automatic int clamp_len(input logic [CFG_W-1:0] v);
    if (v == 0) begin
      return 1;
    end
    if (v > MAX_FRAME) begin
      return MAX_FRAME;
    end
    return int'(v);
  endfunction

  // Advance the expected frame state by one byte and build its result
  function automatic frc_result_t predict_result(input logic [7:0] rx, input logic start);
    frc_result_t   r;
    frame_status_t st;
    int            n;
    int            idx;
    logic          done;
    n   = clamp_len(exp_frame_len);
    idx = start ? 0 : exp_count;
    if (idx == 0) begin
      exp_crc    = '0;
      exp_hdr_ok = (rx == HDR_BYTE);
      exp_func   = '0;
      exp_len    = '0;
    end
    if (idx == 2) begin
      exp_func = rx;
    end
    if (idx == 3) begin
      exp_len = rx;
    end
    done = (idx >= n - 1);
    st   = ST_OK;
    if (done) begin
      if (n < LEN_OVERHEAD) begin
        st = ST_SHORT;
      end else if (int'(exp_len) + LEN_OVERHEAD != n) begin
        st = ST_LEN_ERR;
      end else if (!exp_hdr_ok) begin
        st = ST_BAD_HDR;
      end else if (exp_crc != rx) begin
        st = ST_CRC_ERR;
      end else if (exp_func == ERR_CODE_A || exp_func == ERR_CODE_B) begin
        st = ST_ERR_REPLY;
      end
    end else if (idx >= 1) begin
      exp_crc = dow_crc_step(exp_crc, rx);
    end
    r.byte_index   = idx[IDX_W-1:0];
    r.data_byte    = rx;
    r.in_payload   = (idx >= PAYLOAD_FIRST) && (n >= 2) && (idx <= n - 2);
    r.frame_done   = done;
    r.frame_status = st;
    r.reply_code   = done ? exp_func : 8'h00;
    r.length_field = done ? exp_len : 8'h00;
    exp_count = done ? 0 : idx + 1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    if (err_count < PRINT_MAX) begin
      $display("MISMATCH %s: expected %0h, got %0h (cycle %0d)", what, want_v, got_v, cycles);
    end
    err_count++;
  endtask

  // Track register writes and predict every input transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        exp_frame_len = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_result(in_rx_byte, in_frame_start));
        bytes_sent++;
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_result
    frc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 0, out_data_byte);
      end else begin
        want = expected_results.pop_front();
        if (out_byte_index != want.byte_index)
          report_mismatch("byte_index", want.byte_index, out_byte_index);
        if (out_data_byte != want.data_byte)
          report_mismatch("data_byte", want.data_byte, out_data_byte);
        if (out_in_payload != want.in_payload)
          report_mismatch("in_payload", want.in_payload, out_in_payload);
        if (out_frame_done != want.frame_done)
          report_mismatch("frame_done", want.frame_done, out_frame_done);
        if (out_frame_status != want.frame_status)
          report_mismatch("frame_status", want.frame_status, out_frame_status);
        if (out_reply_code != want.reply_code)
          report_mismatch("reply_code", want.reply_code, out_reply_code);
        if (out_length_field != want.length_field)
          report_mismatch("length_field", want.length_field, out_length_field);
      end
      if (out_frame_done) begin
        frames_done++;
        if (out_frame_status < 6) begin
          status_seen[out_frame_status]++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles,
               expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stall before each transfer, plus any requested hold-off
  initial begin : receiver
    int hold;
    @(posedge clk);
    forever begin
      hold = rx_hold + ((rx_stall_max > 0) ? $urandom_range(0, rx_stall_max) : 0);
      rx_hold = 0;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one byte after a random gap; leave valid high on return
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_start <= start;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every expected result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Build an n-byte reply frame with at most one flaw and send it
  task automatic send_frame(input int n, input flaw_t flaw, input bit use_start);
    logic [7:0] fb[$];
    logic [7:0] crc;
    for (int i = 0; i < n; i++) begin
      fb.push_back(8'($urandom_range(0, 255)));
    end
    if (n >= LEN_OVERHEAD) begin
      fb[0] = HDR_BYTE;
      fb[3] = 8'(n - LEN_OVERHEAD);
      if (fb[2] == ERR_CODE_A || fb[2] == ERR_CODE_B) begin
        fb[2] = 8'h03;
      end
      case (flaw)
        FL_HDR:   fb[0] = HDR_BYTE ^ 8'(1 << $urandom_range(0, 7));
        FL_LEN:   fb[3] = fb[3] ^ 8'($urandom_range(1, 255));
        FL_ERR_A: fb[2] = ERR_CODE_A;
        FL_ERR_B: fb[2] = ERR_CODE_B;
        default:  ;
      endcase
      crc = '0;
      for (int i = 1; i <= n - 2; i++) begin
        crc = dow_crc_step(crc, fb[i]);
      end
      fb[n-1] = (flaw == FL_CRC) ? crc ^ 8'($urandom_range(1, 255)) : crc;
    end
    for (int i = 0; i < n; i++) begin
      send_byte(fb[i], (i == 0) && use_start);
    end
  endtask

  // Random bytes with stray frame starts
  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  // Clean frame at the reset length of six
  task automatic test_default_length();
    send_frame(6, FL_NONE, 1'b1);
    wait_drained();
  endtask

  // Shortest legal frame carrying an error reply
  task automatic test_error_reply_min();
    write_length(5);
    send_frame(5, FL_ERR_B, 1'b1);
    wait_drained();
  endtask

  // One-byte frames, with the zero length treated as one
  task automatic test_tiny_lengths();
    write_length(1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    wait_drained();
    write_length(0);
    send_byte(8'h5A, 1'b0);
    wait_drained();
  endtask

  // Lower the length while a frame is partly received
  task automatic test_length_lowered();
    write_length(20);
    send_byte(HDR_BYTE, 1'b1);
    for (int i = 0; i < 5; i++) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    wait_drained();
    write_length(5);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_drained();
  endtask

  // Long receiver hold-off against a sender with no gaps
  task automatic test_backpressure();
    write_length(8);
    tx_gap_max   = 0;
    rx_stall_max = 0;
    rx_hold      = 80;
    repeat (4) send_frame(8, FL_NONE, 1'b1);
    wait_drained();
    tx_gap_max   = GAP_MAX;
    rx_stall_max = GAP_MAX;
  endtask

  // Sender pauses for a full drain, then resumes without a frame start
  task automatic test_sender_pause();
    write_length(7);
    send_frame(7, FL_NONE, 1'b1);
    wait_drained();
    send_frame(7, FL_CRC, 1'b0);
    wait_drained();
  endtask

  // Phases of random lengths, idling modes and frame kinds
  task automatic test_random_traffic();
    int start_bytes;
    int cfg_v;
    int n;
    int r;
    flaw_t flaw;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RAND_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 55)      cfg_v = $urandom_range(5, 12);
      else if (r < 70) cfg_v = $urandom_range(1, 4);
      else if (r < 82) cfg_v = $urandom_range(13, 40);
      else if (r < 88) cfg_v = MAX_FRAME;
      else if (r < 94) cfg_v = $urandom_range(MAX_FRAME + 1, 127);
      else             cfg_v = 0;
      write_length(cfg_v);
      n = clamp_len(cfg_v[CFG_W-1:0]);
      tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      repeat ($urandom_range(2, 6)) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          flaw = ($urandom_range(0, 9) < 4) ? FL_NONE : flaw_t'($urandom_range(1, 5));
          send_frame(n, flaw, $urandom_range(0, 4) != 0);
        end else begin
          send_noise($urandom_range(1, n + 3));
        end
      end
      wait_drained();
    end
    tx_gap_max   = GAP_MAX;
    rx_stall_max = GAP_MAX;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_length();
    test_error_reply_min();
    test_tiny_lengths();
    test_length_lowered();
    test_backpressure();
    test_sender_pause();
    test_random_traffic();
    $display("Covered %0d bytes in %0d completed frames, lengths 0 to 127, with stalls",
             bytes_sent, frames_done);
    $display("Status counts ok/short/len/hdr/crc/err reply: %0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
